// ----- design/cursor_sequence_engine_top_defines.svh -----
// Assertion macros for the cursor sequence engine checker.
`ifndef CURSOR_SEQUENCE_ENGINE_TOP_DEFINES_SVH
`define CURSOR_SEQUENCE_ENGINE_TOP_DEFINES_SVH

// Implication checked on every rising clock edge, off while reset is high.
`define CSE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cse_pkg.sv -----
// Shared constants, types and command codes for the cursor sequence engine.
package cse_pkg;

   localparam int DEPTH      = 32;
   localparam int WORD_WIDTH = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMD_W      = 3;
   localparam int VALUE_W    = 64;
   localparam int COUNT_W    = 6;
   localparam int RSP_W      = 72;
   localparam int REQ_W      = 64;

   localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      idx_type     pos;
      word_type    word;
   } cell_ctrl_type;

   typedef struct packed {
      cnt_type total;
      logic    cursor_on;
      logic    error;
      logic    use_new;
      idx_type rd_sel;
   } ctrl_status_type;

endpackage

// ----- design/cse_cell.sv -----
// One storage cell of the entry chain: holds a word, shifts from a neighbor.
module cse_cell (
   input  logic                   clock,
   input  cse_pkg::idx_type       cell_index,
   input  cse_pkg::cell_ctrl_type ctrl,
   input  cse_pkg::word_type      left_word,
   input  cse_pkg::word_type      right_word,
   output cse_pkg::word_type      word
);

   cse_pkg::word_type word_ff;
   cse_pkg::word_type word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         cse_pkg::CELL_INSERT: begin
            if (cell_index > ctrl.pos) begin
               word_in = left_word;
            end else if (cell_index == ctrl.pos) begin
               word_in = ctrl.word;
            end
         end
         cse_pkg::CELL_REMOVE: begin
            if (cell_index >= ctrl.pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ----- design/cse_ctrl.sv -----
// Command decode, entry count and cursor registers; drives the cell chain.
module cse_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [cse_pkg::CMD_W-1:0] cmd,
   input  cse_pkg::word_type        word,
   output cse_pkg::cell_ctrl_type   cell_ctrl,
   output cse_pkg::ctrl_status_type status
);

   cse_pkg::cnt_type total_ff, total_in;
   logic             on_ff, on_in;
   cse_pkg::idx_type pos_ff, pos_in;

   cse_pkg::cnt_type pos_next_cnt;
   logic             full;
   cse_pkg::cell_op_type op;
   cse_pkg::idx_type slot;
   logic             err;
   logic             use_new;
   cse_pkg::idx_type rd_sel;

   assign pos_next_cnt = cse_pkg::CNT_W'(pos_ff) + cse_pkg::CNT_W'(1);
   assign full         = (total_ff == cse_pkg::CNT_W'(cse_pkg::DEPTH));

   always_comb begin
      total_in = total_ff;
      on_in    = on_ff;
      pos_in   = pos_ff;
      op       = cse_pkg::CELL_HOLD;
      slot     = pos_ff;
      err      = 1'b0;
      use_new  = 1'b0;
      rd_sel   = pos_ff;
      case (cmd)
         cse_pkg::CMD_START: begin
            rd_sel = '0;
            if (total_ff != '0) begin
               on_in  = 1'b1;
               pos_in = '0;
            end else begin
               on_in = 1'b0;
            end
         end
         cse_pkg::CMD_ADVANCE: begin
            rd_sel = pos_next_cnt[cse_pkg::IDX_W-1:0];
            if (!on_ff) begin
               err = 1'b1;
            end else if (pos_next_cnt < total_ff) begin
               pos_in = pos_next_cnt[cse_pkg::IDX_W-1:0];
            end else begin
               on_in = 1'b0;
            end
         end
         cse_pkg::CMD_INSERT, cse_pkg::CMD_ATTACH: begin
            if (full) begin
               err = 1'b1;
            end else begin
               if (cmd == cse_pkg::CMD_INSERT) begin
                  slot = on_ff ? pos_ff : '0;
               end else begin
                  slot = on_ff ? pos_next_cnt[cse_pkg::IDX_W-1:0]
                               : total_ff[cse_pkg::IDX_W-1:0];
               end
               op       = cse_pkg::CELL_INSERT;
               total_in = total_ff + cse_pkg::CNT_W'(1);
               pos_in   = slot;
               on_in    = 1'b1;
               use_new  = 1'b1;
            end
         end
         cse_pkg::CMD_REMOVE: begin
            rd_sel = pos_next_cnt[cse_pkg::IDX_W-1:0];
            if (!on_ff || total_ff == '0) begin
               err = 1'b1;
            end else begin
               op       = cse_pkg::CELL_REMOVE;
               total_in = total_ff - cse_pkg::CNT_W'(1);
               if (pos_next_cnt >= total_ff) begin
                  on_in = 1'b0;
               end
            end
         end
         default: begin
            rd_sel = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         on_ff    <= 1'b0;
         pos_ff   <= '0;
      end else if (accept) begin
         total_ff <= total_in;
         on_ff    <= on_in;
         pos_ff   <= pos_in;
      end
   end

   assign cell_ctrl.op   = accept ? op : cse_pkg::CELL_HOLD;
   assign cell_ctrl.pos  = slot;
   assign cell_ctrl.word = word;

   assign status.total     = total_in;
   assign status.cursor_on = on_in;
   assign status.error     = err;
   assign status.use_new   = use_new;
   assign status.rd_sel    = rd_sel;

endmodule

// ----- design/cursor_sequence_engine_top.sv -----
// Cursor sequence engine: chain of word cells with cursor control and response register.
// Latency: the response to a transaction is valid the cycle after it is accepted.
// Throughput: one transaction per cycle while the response is not stalled; every insert or remove
//   shifts the cells from the target slot upward, away from or toward that slot.
// Reset: synchronous, clears the entry count, the cursor and the response valid;
//   cell contents stay undefined until written.
module cursor_sequence_engine_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cse_pkg::REQ_W-1:0]   req_tdata,  // entry_value[63:0]
   input  logic [cse_pkg::CMD_W-1:0]   req_tuser,  // cmd[2:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cse_pkg::RSP_W-1:0]   rsp_tdata   // item_count[5:0], cursor_valid[6],
                                                   // current_word[70:7], op_error[71]
);

   logic                    accept;
   cse_pkg::word_type       new_word;
   cse_pkg::cell_ctrl_type  cell_ctrl;
   cse_pkg::ctrl_status_type status;
   cse_pkg::word_type       cell_word [cse_pkg::DEPTH];
   cse_pkg::word_type       cur_word;

   logic                       rsp_valid_ff;
   logic [cse_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign new_word   = req_tdata[cse_pkg::WORD_WIDTH-1:0];

   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_tuser),
      .word      (new_word),
      .cell_ctrl (cell_ctrl),
      .status    (status)
   );

   for (genvar i = 0; i < cse_pkg::DEPTH; i++) begin : g_cell
      cse_pkg::word_type left_word;
      cse_pkg::word_type right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_left
         assign left_word = cell_word[i-1];
      end
      if (i == cse_pkg::DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_right
         assign right_word = cell_word[i+1];
      end
      cse_cell u_cell (
         .clock      (clock),
         .cell_index (cse_pkg::IDX_W'(i)),
         .ctrl       (cell_ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   always_comb begin
      if (!status.cursor_on) begin
         cur_word = '0;
      end else if (status.use_new) begin
         cur_word = new_word;
      end else begin
         cur_word = cell_word[status.rd_sel];
      end
      rsp_data_in = {status.error,
                     cse_pkg::VALUE_W'(cur_word),
                     status.cursor_on,
                     cse_pkg::COUNT_W'(status.total)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/cse_checker.sv -----
// Port-level checker for the cursor sequence engine, bound to the top level.
`include "cursor_sequence_engine_top_defines.svh"

module cse_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [cse_pkg::RSP_W-1:0] rsp_tdata
);

   logic [cse_pkg::COUNT_W-1:0] count;
   logic                        cursor_valid;
   logic [cse_pkg::VALUE_W-1:0] current_word;

   assign count        = rsp_tdata[5:0];
   assign cursor_valid = rsp_tdata[6];
   assign current_word = rsp_tdata[70:7];

   // stalled response transaction holds
   `CSE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")
   // every accepted request yields a response next cycle
   `CSE_ASSERT_NEXT(a_rsp_follows, req_tvalid && req_tready, rsp_tvalid, "no response after accepted request")
   // no cursor means a zero word
   `CSE_ASSERT_IMP(a_word_zero, rsp_tvalid && !cursor_valid, current_word == '0, "word nonzero without cursor")
   // count stays in range and a valid cursor needs an entry
   `CSE_ASSERT_IMP(a_count_range, rsp_tvalid, (count <= cse_pkg::COUNT_W'(cse_pkg::DEPTH)) && (!cursor_valid || count != '0), "count out of range")

endmodule

bind cursor_sequence_engine_top cse_checker u_cse_checker (.*);
